FILE: rtl/hpt_pkg.sv
package hpt_pkg;

  localparam int unsigned TS_W       = 16;
  localparam int unsigned OVF_W      = 16;
  localparam int unsigned RATE_W     = 27;
  localparam int unsigned PULSE_W    = 7;
  localparam int unsigned RPM_W      = 32;
  localparam int unsigned CFG_DATA_W = 27;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned NUM_W      = 33;

  localparam logic [OVF_W-1:0]   OVF_MAX    = '1;
  localparam logic [RPM_W-1:0]   RPM_MAX    = '1;
  localparam logic [NUM_W-1:0]   RPM_SCALE  = NUM_W'(60);

  localparam logic [RATE_W-1:0]  RATE_RST   = RATE_W'(16000000);
  localparam logic [PULSE_W-1:0] PULSE0_RST = PULSE_W'(4);
  localparam logic [PULSE_W-1:0] PULSE1_RST = PULSE_W'(2);
  localparam logic [OVF_W-1:0]   TMO_RST    = OVF_W'(244);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE    = 2'd0,
    CFG_PULSE0  = 2'd1,
    CFG_PULSE1  = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic prep;
    logic mul;
    logic step;
    logic write_speed;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic in_edge;
    logic present;
    logic nonpos;
    logic div_done;
  } dp_status_t;

endpackage

FILE: rtl/hpt_if.sv
interface hpt_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic                      channel;
  logic [hpt_pkg::TS_W-1:0]  timer_value;

  modport source (output valid, req_type, channel, timer_value, input ready);
  modport sink   (input valid, req_type, channel, timer_value, output ready);
endinterface

interface hpt_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [hpt_pkg::RPM_W-1:0] rpm_first;
  logic [hpt_pkg::RPM_W-1:0] rpm_second;
  logic                      measured;

  modport source (output valid, rpm_first, rpm_second, measured, input ready);
  modport sink   (input valid, rpm_first, rpm_second, measured, output ready);
endinterface

FILE: rtl/hpt_datapath.sv
module hpt_datapath #(
  parameter int unsigned TIMER_WIDTH = 16,
  parameter int unsigned CHANNELS    = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hpt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           req_type_i,
  input  logic                           channel_i,
  input  logic [hpt_pkg::TS_W-1:0]       timer_value_i,
  input  hpt_pkg::dp_cmd_t               cmd_i,
  output hpt_pkg::dp_status_t            status_o,
  output logic [hpt_pkg::RPM_W-1:0]      rpm_first_o,
  output logic [hpt_pkg::RPM_W-1:0]      rpm_second_o,
  output logic                           measured_o
);
  import hpt_pkg::*;

  localparam int unsigned CAP_W  = (TIMER_WIDTH < TS_W) ? TIMER_WIDTH : TS_W;
  localparam int unsigned TOT_W  = OVF_W + TIMER_WIDTH;
  localparam int unsigned DEN_W  = TOT_W + PULSE_W;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [RATE_W-1:0]  rate_q;
  logic [PULSE_W-1:0] pulse0_q;
  logic [PULSE_W-1:0] pulse1_q;
  logic [OVF_W-1:0]   timeout_q;

  logic [CAP_W-1:0]   last_cap_q [CHANNELS];
  logic [OVF_W-1:0]   ovf_q      [CHANNELS];
  logic [RPM_W-1:0]   speed_q    [CHANNELS];
  logic [OVF_W-1:0]   ovf_inc    [CHANNELS];

  logic               ch_q;
  logic [CAP_W-1:0]   cap_q;
  logic               meas_q;
  logic [TOT_W-1:0]   counts_q;
  logic [DEN_W-1:0]   den_q;
  logic [DEN_W-1:0]   rem_q;
  logic [NUM_W-1:0]   quo_q;
  logic [STEP_W-1:0]  step_q;

  logic [CAP_W-1:0]   prev_sel;
  logic [OVF_W-1:0]   ovf_sel;
  logic [TOT_W-1:0]   total;
  logic [TOT_W:0]     diff;
  logic               present;
  logic               nonpos;
  logic [PULSE_W-1:0] pulse_sel;
  logic [DEN_W:0]     trial;
  logic               ge;
  logic [RPM_W-1:0]   rpm_sat;
  logic [RPM_W-1:0]   second_sel;

  always_comb begin
    prev_sel   = '0;
    ovf_sel    = '0;
    second_sel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      ovf_inc[i] = (ovf_q[i] == OVF_MAX) ? ovf_q[i] : ovf_q[i] + OVF_W'(1);
      if (int'(ch_q) == i) begin
        prev_sel = last_cap_q[i];
        ovf_sel  = ovf_q[i];
      end
      if (i == 1) begin
        second_sel = speed_q[i];
      end
    end
  end

  assign present   = int'(ch_q) < CHANNELS;
  assign total     = {ovf_sel, {TIMER_WIDTH{1'b0}}} + TOT_W'(cap_q);
  assign diff      = {1'b0, total} - (TOT_W + 1)'(prev_sel);
  assign nonpos    = diff[TOT_W] || (diff == '0);
  assign pulse_sel = ch_q ? pulse1_q : pulse0_q;

  assign trial   = {rem_q, quo_q[NUM_W-1]} - {1'b0, den_q};
  assign ge      = !trial[DEN_W];
  assign rpm_sat = quo_q[NUM_W-1] ? RPM_MAX : quo_q[RPM_W-1:0];

  assign status_o.in_edge  = req_type_i;
  assign status_o.present  = present;
  assign status_o.nonpos   = nonpos;
  assign status_o.div_done = (step_q == STEP_W'(NUM_W));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= RATE_RST;
      pulse0_q  <= PULSE0_RST;
      pulse1_q  <= PULSE1_RST;
      timeout_q <= TMO_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        last_cap_q[i] <= '0;
        ovf_q[i]      <= '0;
        speed_q[i]    <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_RATE:    rate_q    <= cfg_data_i[RATE_W-1:0];
          CFG_PULSE0:  pulse0_q  <= cfg_data_i[PULSE_W-1:0];
          CFG_PULSE1:  pulse1_q  <= cfg_data_i[PULSE_W-1:0];
          CFG_TIMEOUT: timeout_q <= cfg_data_i[OVF_W-1:0];
          default: ;
        endcase
      end
      for (int i = 0; i < CHANNELS; i++) begin
        if (cmd_i.accept && !req_type_i) begin
          ovf_q[i] <= ovf_inc[i];
          if (ovf_inc[i] >= timeout_q) begin
            speed_q[i] <= '0;
          end
        end
        if (int'(ch_q) == i) begin
          if (cmd_i.prep) begin
            last_cap_q[i] <= cap_q;
            ovf_q[i]      <= '0;
            if (nonpos) begin
              speed_q[i] <= RPM_MAX;
            end
          end
          if (cmd_i.write_speed) begin
            speed_q[i] <= rpm_sat;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q   <= channel_i;
      cap_q  <= timer_value_i[CAP_W-1:0];
      meas_q <= 1'b0;
    end
    if (cmd_i.prep) begin
      counts_q <= diff[TOT_W-1:0];
      meas_q   <= present;
    end
    if (cmd_i.mul) begin
      den_q  <= DEN_W'(counts_q) * DEN_W'(pulse_sel);
      quo_q  <= NUM_W'(rate_q) * RPM_SCALE;
      rem_q  <= '0;
      step_q <= '0;
    end
    if (cmd_i.step) begin
      rem_q  <= ge ? trial[DEN_W-1:0] : {rem_q[DEN_W-2:0], quo_q[NUM_W-1]};
      quo_q  <= {quo_q[NUM_W-2:0], ge};
      step_q <= step_q + STEP_W'(1);
    end
    if (cmd_i.load_out) begin
      rpm_first_o  <= speed_q[0];
      rpm_second_o <= second_sel;
      measured_o   <= meas_q;
    end
  end

endmodule

FILE: rtl/hpt_ctrl.sv
module hpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  hpt_pkg::dp_status_t status_i,
  output hpt_pkg::dp_cmd_t    cmd_o
);
  import hpt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.in_edge ? S_PREP : S_FINISH;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = (!status_i.present || status_i.nonpos) ? S_FINISH : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.write_speed = 1'b1;
          state_d           = S_FINISH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/hall_period_tachometer_top.sv
// An overflow tick goes from acceptance through the finish state into the output register.
// A hall edge passes through the period, product, 33-step restoring divider and write-back
// steps; with a non-positive period or an absent channel it skips to the finish state.
// One transaction is in flight at a time; a finished result may wait in the output register.
// Reset is asynchronous and active low; it restores the registers to their
// defaults and clears all captures, overflow counts and speeds.
module hall_period_tachometer_top #(
  parameter int unsigned TIMER_WIDTH = 16,
  parameter int unsigned CHANNELS    = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hpt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  hpt_req_if.sink                        req_i,
  hpt_rsp_if.source                      rsp_o
);
  import hpt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  hpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hpt_datapath #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .CHANNELS    (CHANNELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_i.req_type),
    .channel_i     (req_i.channel),
    .timer_value_i (req_i.timer_value),
    .cmd_i         (cmd),
    .status_o      (status),
    .rpm_first_o   (rsp_o.rpm_first),
    .rpm_second_o  (rsp_o.rpm_second),
    .measured_o    (rsp_o.measured)
  );

endmodule

FILE: rtl/hpt_checker.sv
module hpt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic req_type_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic rsp_measured_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("Result withdrawn before it was taken.");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("Second transaction accepted while one is in progress.");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && !req_type_i && !rsp_valid_i |=> ##1 (rsp_valid_i && !rsp_measured_i))
    else $error("Tick result late or reported as a measurement.");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !rsp_valid_i)
    else $error("Result presented during reset.");

endmodule

bind hall_period_tachometer_top hpt_checker u_hpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_type_i     (req_i.req_type),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_measured_i (rsp_o.measured)
);

FILE: tb/tach_tb_pkg.sv
package tach_tb_pkg;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_EDGE = 1'b1
  } tach_req_e;

endpackage

FILE: tb/speed_checker.sv
module speed_checker
  import hpt_pkg::*;
  import tach_tb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hpt_req_if                    req_mon,
  hpt_rsp_if                    rsp_mon,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RPM_W-1:0] rpm_first;
    logic [RPM_W-1:0] rpm_second;
    logic             measured;
  } speed_report_t;

  logic [RATE_W-1:0]  rate_hz;
  logic [PULSE_W-1:0] pulses_per_rev [2];
  logic [OVF_W-1:0]   timeout_ticks;
  logic [TS_W-1:0]    last_stamp [2];
  logic [OVF_W-1:0]   ovf_ticks [2];
  logic [RPM_W-1:0]   rpm_now [2];
  speed_report_t      reports_due [$];
  int                 mismatches;

  function automatic void apply_setting(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_RATE:    rate_hz = data[RATE_W-1:0];
      CFG_PULSE0:  pulses_per_rev[0] = data[PULSE_W-1:0];
      CFG_PULSE1:  pulses_per_rev[1] = data[PULSE_W-1:0];
      CFG_TIMEOUT: timeout_ticks = data[OVF_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic speed_report_t predict_report(logic kind, logic ch,
                                                   logic [TS_W-1:0] capture);
    speed_report_t rep;
    logic [63:0]   span_end;
    logic [63:0]   divisor;
    logic [63:0]   quotient;
    rep.measured = 1'b0;
    if (kind == REQ_TICK) begin
      for (int c = 0; c < 2; c++) begin
        if (ovf_ticks[c] != OVF_MAX) ovf_ticks[c] = ovf_ticks[c] + 1'b1;
        if (ovf_ticks[c] >= timeout_ticks) rpm_now[c] = '0;
      end
    end else begin
      span_end = {32'b0, ovf_ticks[ch], capture};
      divisor  = (span_end - 64'(last_stamp[ch])) * 64'(pulses_per_rev[ch]);
      if (span_end <= 64'(last_stamp[ch]) || divisor == 64'd0) begin
        rpm_now[ch] = RPM_MAX;
      end else begin
        quotient = (64'd60 * 64'(rate_hz)) / divisor;
        rpm_now[ch] = (quotient > 64'(RPM_MAX)) ? RPM_MAX : quotient[RPM_W-1:0];
      end
      last_stamp[ch] = capture;
      ovf_ticks[ch]  = '0;
      rep.measured   = 1'b1;
    end
    rep.rpm_first  = rpm_now[0];
    rep.rpm_second = rpm_now[1];
    return rep;
  endfunction

  function automatic void check_field(string name, logic [RPM_W-1:0] want,
                                      logic [RPM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_report();
    speed_report_t due;
    if (reports_due.size() == 0) begin
      $error("unexpected speed report: rpm_first %0d, rpm_second %0d, measured %0b",
             rsp_mon.rpm_first, rsp_mon.rpm_second, rsp_mon.measured);
      mismatches++;
    end else begin
      due = reports_due.pop_front();
      check_field("rpm_first", due.rpm_first, rsp_mon.rpm_first);
      check_field("rpm_second", due.rpm_second, rsp_mon.rpm_second);
      check_field("measured", RPM_W'(due.measured), RPM_W'(rsp_mon.measured));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_hz           = RATE_RST;
      pulses_per_rev[0] = PULSE0_RST;
      pulses_per_rev[1] = PULSE1_RST;
      timeout_ticks     = TMO_RST;
      for (int c = 0; c < 2; c++) begin
        last_stamp[c] = '0;
        ovf_ticks[c]  = '0;
        rpm_now[c]    = '0;
      end
      reports_due.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) apply_setting(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (req_mon.valid && req_mon.ready) begin
        reports_due.push_back(predict_report(req_mon.req_type, req_mon.channel,
                                             req_mon.timer_value));
      end
      if (rsp_mon.valid && rsp_mon.ready) compare_report();
      fail_count_o <= mismatches;
      pending_o    <= reports_due.size();
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hpt_pkg::*;
  import tach_tb_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  bit                    calm = 1'b0;
  bit                    hold_rsp_long = 1'b0;
  logic [TS_W-1:0]       prev_capture [2];

  hpt_req_if req ();
  hpt_rsp_if rsp ();

  hall_period_tachometer_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  speed_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .req_mon      (req),
    .rsp_mon      (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // The receiver refuses results at random, and once for a long stretch so that the
  // block fills up and must hold off further transactions.
  initial begin
    int pick;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      pick = $urandom_range(0, 99);
      if (hold_rsp_long) begin
        rsp.ready = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_rsp_long = 1'b0;
      end else if (calm) begin
        rsp.ready = 1'b1;
      end else if (pick < 20) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else if (pick < 25) begin
        rsp.ready = 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  task automatic offer(tach_req_e kind, logic ch, logic [TS_W-1:0] capture);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      req.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req.valid       = 1'b1;
    req.req_type    = kind;
    req.channel     = ch;
    req.timer_value = capture;
    do begin
      @(posedge clk_i);
    end while (!req.ready);
    if (kind == REQ_EDGE) prev_capture[ch] = capture;
  endtask

  task automatic send_tick();
    offer(REQ_TICK, 1'($urandom), TS_W'($urandom));
  endtask

  task automatic settle();
    @(negedge clk_i);
    req.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_tach_regs(logic [RATE_W-1:0] rate, logic [PULSE_W-1:0] p0,
                               logic [PULSE_W-1:0] p1, logic [OVF_W-1:0] tmo);
    settle();
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = CFG_RATE;
    cfg_data = CFG_DATA_W'(rate);
    @(negedge clk_i);
    cfg_idx  = CFG_PULSE0;
    cfg_data = {20'($urandom), p0};
    @(negedge clk_i);
    cfg_idx  = CFG_PULSE1;
    cfg_data = {20'($urandom), p1};
    @(negedge clk_i);
    cfg_idx  = CFG_TIMEOUT;
    cfg_data = {11'($urandom), tmo};
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Mostly plausible hall sequences: each edge a short or long span after the
  // previous one on that channel, with ticks between, plus arbitrary captures.
  task automatic run_random(int count);
    int   done;
    int   pick;
    int   burst;
    logic ch;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      ch   = 1'($urandom_range(0, 1));
      if (pick < 8) begin
        burst = $urandom_range(2, 12);
        repeat (burst) send_tick();
        done += burst;
      end else if (pick < 35) begin
        send_tick();
        done++;
      end else if (pick < 70) begin
        offer(REQ_EDGE, ch, prev_capture[ch] + TS_W'($urandom_range(1, 2000)));
        done++;
      end else if (pick < 90) begin
        offer(REQ_EDGE, ch, prev_capture[ch] + TS_W'($urandom_range(1, 65535)));
        done++;
      end else begin
        offer(REQ_EDGE, ch, TS_W'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_RATE;
    cfg_data        = '0;
    req.valid       = 1'b0;
    req.req_type    = REQ_TICK;
    req.channel     = 1'b0;
    req.timer_value = '0;
    prev_capture[0] = '0;
    prev_capture[1] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    offer(REQ_EDGE, 1'b0, 16'h0000);
    offer(REQ_EDGE, 1'b0, 16'd1000);
    offer(REQ_EDGE, 1'b1, 16'hFFFF);
    offer(REQ_EDGE, 1'b1, 16'h8000);
    send_tick();
    send_tick();
    offer(REQ_EDGE, 1'b0, 16'd500);
    offer(REQ_EDGE, 1'b0, 16'd500);

    set_tach_regs(RATE_W'((1 << RATE_W) - 1), 7'd1, 7'd127, 16'd1);
    offer(REQ_EDGE, 1'b0, 16'd501);
    offer(REQ_EDGE, 1'b1, 16'h8001);
    send_tick();
    offer(REQ_EDGE, 1'b0, 16'h0000);

    set_tach_regs('0, 7'd0, 7'd64, 16'd0);
    offer(REQ_EDGE, 1'b0, 16'd100);
    offer(REQ_EDGE, 1'b1, 16'h9000);
    send_tick();
    offer(REQ_EDGE, 1'b0, 16'hFFFF);
    offer(REQ_EDGE, 1'b1, 16'h0000);

    set_tach_regs(RATE_W'(16000000), 7'd4, 7'd2, 16'd244);
    run_random(220);
    set_tach_regs(RATE_W'(1), 7'd64, 7'd1, 16'd3);
    run_random(200);
    set_tach_regs(RATE_W'(100000000), 7'd7, 7'd13, 16'hFFFF);
    run_random(100);
    hold_rsp_long = 1'b1;
    run_random(100);
    set_tach_regs(RATE_W'($urandom_range(1, (1 << RATE_W) - 1)),
                  PULSE_W'($urandom_range(1, 127)), PULSE_W'($urandom_range(1, 127)),
                  OVF_W'($urandom_range(1, 20)));
    run_random(200);
    set_tach_regs(RATE_W'((1 << RATE_W) - 1), 7'd127, 7'd127, 16'd40);
    run_random(200);
    set_tach_regs(RATE_W'($urandom_range(1000000, 50000000)),
                  PULSE_W'($urandom_range(1, 64)), PULSE_W'($urandom_range(1, 64)),
                  OVF_W'($urandom_range(2, 30)));
    calm = 1'b1;
    run_random(230);

    settle();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
